>>> design/lca_pkg.sv
// Shared constants and types for the Life generation step block.
// Used by life_cellular_automaton_step; no dependencies.
package lca_pkg;

    // Frame size limits and reset sizes
    localparam int MAX_WIDTH_DEFAULT = 256;
    localparam int MAX_HEIGHT        = 1024;
    localparam int WIDTH_RESET       = 240;
    localparam int HEIGHT_RESET      = 160;
    localparam int MIN_SIZE          = 3;

    // Register field widths
    localparam int FRAME_WIDTH_W  = 9;
    localparam int FRAME_HEIGHT_W = 11;
    localparam int CFG_DATA_W     = 11;
    localparam int ROW_W          = 10;

    // Line store entry: {older row, newer row}
    localparam int LINE_W = 2;

    // Rule B3/S23 counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

endpackage

>>> design/lca_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// Read returns the old contents when read and write hit the same entry.
// Standalone; depends on no package.
module lca_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/life_cellular_automaton_step.sv
// Top level of the Life (B3/S23) generation step over a raster cell stream.
// Depends on lca_pkg and lca_ram (line store memory).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------
//  in      | input     | in_valid / in_ready    | cell_alive, frame_start
//  out     | output    | out_valid / out_ready  | next_alive, frame_end
//  cfg     | input     | cfg_write (no wait)    | cfg_index, cfg_data
//
// One cell transfer per clock sustained while the output is not stalled; a result
// passes from the stage 1 registers into the output register and leaves from there. The
// rate is set by the line store RAM: one read at the transfer, one write back
// when stage 1 advances.
// Reset (rst_n, async low) clears position, window, pipeline and output valid;
// the line store is not cleared and needs no clearing pass.
// A stalled output holds the pipeline stage and in turn drops in_ready.
module life_cellular_automaton_step #(
    parameter int MAX_WIDTH = lca_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            cell_alive,
    input  logic                            frame_start,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            next_alive,
    output logic                            frame_end,

    input  logic                            cfg_write,
    input  logic [0:0]                      cfg_index,
    input  logic [lca_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = 14;
    localparam int ROW_W = lca_pkg::ROW_W;
    localparam int RESET_W =
        (lca_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : lca_pkg::WIDTH_RESET;
    localparam logic [COL_W-1:0] RESET_LAST_COL = COL_W'(RESET_W - 1);
    localparam logic [ROW_W-1:0] RESET_LAST_ROW = ROW_W'(lca_pkg::HEIGHT_RESET - 1);
    localparam logic [CMP_W-1:0] MAX_W_CMP = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] MAX_H_CMP = CMP_W'(lca_pkg::MAX_HEIGHT);
    localparam logic [CMP_W-1:0] MIN_CMP   = CMP_W'(lca_pkg::MIN_SIZE);

    // ------------------------------------------------------------------
    // Configuration: keep the clamped last column / last row indexes
    // ------------------------------------------------------------------
    logic [COL_W-1:0] last_col_reg, last_col_next;
    logic [ROW_W-1:0] last_row_reg, last_row_next;
    logic [CMP_W-1:0] cfg_w_val, cfg_h_val;

    assign cfg_w_val = CMP_W'(cfg_data[lca_pkg::FRAME_WIDTH_W-1:0]);
    assign cfg_h_val = CMP_W'(cfg_data[lca_pkg::FRAME_HEIGHT_W-1:0]);

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lca_pkg::CFG_FRAME_WIDTH:
                begin
                    if (cfg_w_val < MIN_CMP)
                        last_col_next = COL_W'(lca_pkg::MIN_SIZE - 1);
                    else if (cfg_w_val > MAX_W_CMP)
                        last_col_next = COL_W'(MAX_WIDTH - 1);
                    else
                        last_col_next = COL_W'(cfg_w_val - CMP_W'(1));
                end
                lca_pkg::CFG_FRAME_HEIGHT:
                begin
                    if (cfg_h_val < MIN_CMP)
                        last_row_next = ROW_W'(lca_pkg::MIN_SIZE - 1);
                    else if (cfg_h_val > MAX_H_CMP)
                        last_row_next = ROW_W'(lca_pkg::MAX_HEIGHT - 1);
                    else
                        last_row_next = ROW_W'(cfg_h_val - CMP_W'(1));
                end
                default:
                begin
                    last_col_next = last_col_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position, border masking, line store read issue
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] c0;
    logic [ROW_W-1:0] r0;
    logic             border0;
    logic             cur0;
    logic             emit0;
    logic             fend0;
    logic             in_xfer;

    assign c0      = frame_start ? '0 : col_reg;
    assign r0      = frame_start ? '0 : row_reg;
    assign border0 = (c0 == '0) || (c0 >= last_col_reg) ||
                     (r0 == '0) || (r0 >= last_row_reg);
    assign cur0    = cell_alive & ~border0;
    assign emit0   = (c0 >= COL_W'(2)) && (c0 <= last_col_reg) &&
                     (r0 >= ROW_W'(2)) && (r0 <= last_row_reg);
    assign fend0   = (r0 == last_row_reg) && (c0 == last_col_reg);
    assign in_xfer = in_valid && in_ready;

    // Advance the raster position; wrap the row at the last column
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (in_xfer)
        begin
            if (c0 >= last_col_reg)
            begin
                col_next = '0;
                row_next = (r0 >= last_row_reg) ? '0 : r0 + ROW_W'(1);
            end
            else
            begin
                col_next = c0 + COL_W'(1);
                row_next = r0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: read data back, write line store, slide the window
    // ------------------------------------------------------------------
    logic                       s1_valid_reg, s1_valid_next;
    logic [COL_W-1:0]           s1_col_reg;
    logic                       s1_cur_reg;
    logic                       s1_emit_reg;
    logic                       s1_fend_reg;
    logic                       s1_adv;
    logic                       byp_valid_reg, byp_valid_next;
    logic [lca_pkg::LINE_W-1:0] byp_data_reg;
    logic [lca_pkg::LINE_W-1:0] ram_rdata;
    logic [lca_pkg::LINE_W-1:0] line_rd;
    logic [lca_pkg::LINE_W-1:0] line_wr;
    logic [8:0]                 win_reg, win_next;
    logic                       top1, mid1;

    logic out_valid_reg, out_valid_next;
    logic next_alive_reg;
    logic frame_end_reg;

    // Advance stage 1 only when the output register can take a result
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    assign s1_valid_next = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);

    // Forward the entry written at the same edge as the read of that entry
    assign byp_valid_next = in_xfer ? (s1_adv && (s1_col_reg == c0)) : byp_valid_reg;

    assign line_rd = byp_valid_reg ? byp_data_reg : ram_rdata;
    assign top1    = line_rd[1];
    assign mid1    = line_rd[0];
    assign line_wr = {mid1, s1_cur_reg};

    // Newest column in the top bits; bit 0 of a column is the upper row
    assign win_next = s1_adv ? {s1_cur_reg, mid1, top1, win_reg[8:3]} : win_reg;

    lca_ram #(
        .WIDTH (lca_pkg::LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (line_wr),
        .re    (in_xfer),
        .raddr (c0),
        .rdata (ram_rdata)
    );

    // Neighbor count and B3/S23 rule on the updated window
    logic [3:0] nbr_count;
    logic       rule_alive;

    always_comb
    begin
        nbr_count = '0;
        for (int i = 0; i < 9; i++)
        begin
            if (i != 4)
                nbr_count = nbr_count + 4'(win_next[i]);
        end
        rule_alive = (nbr_count == lca_pkg::BIRTH_COUNT) ||
                     (win_next[4] && (nbr_count == lca_pkg::SURVIVE_COUNT));
    end

    assign out_valid_next = (s1_adv && s1_emit_reg) ? 1'b1 :
                            (out_ready ? 1'b0 : out_valid_reg);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_col_reg  <= RESET_LAST_COL;
            last_row_reg  <= RESET_LAST_ROW;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
            win_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            last_col_reg  <= last_col_next;
            last_row_reg  <= last_row_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            byp_valid_reg <= byp_valid_next;
            win_reg       <= win_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_col_reg   <= c0;
            s1_cur_reg   <= cur0;
            s1_emit_reg  <= emit0;
            s1_fend_reg  <= fend0;
            byp_data_reg <= line_wr;
        end
        if (s1_adv && s1_emit_reg)
        begin
            next_alive_reg <= rule_alive;
            frame_end_reg  <= s1_fend_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign next_alive = next_alive_reg;
    assign frame_end  = frame_end_reg;

`ifndef SYNTHESIS
    a_byp_on_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s1_adv && (s1_col_reg == c0)) |=> byp_valid_reg)
        else $error("same-entry read after write not forwarded");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input stalled with empty pipeline stage");

    a_emit_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_emit_reg) |=> out_valid_reg)
        else $error("emitted result lost before output register");

    a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("stage 1 item changed while stalled");
`endif

endmodule
